// ===== src/svt_pkg.sv =====
package svt_pkg;

  // Default table depth
  localparam int unsigned SvtCapacity = 64;

  // Operation codes on mode
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load_op;  // capture operand from input transaction
    logic cmp_en;   // register compare vectors
    logic commit;   // apply update, load result register
  } svt_cmd_t;

endpackage

// ===== src/svt_ctrl.sv =====
module svt_ctrl
  import svt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output svt_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       commit;
  logic       load;

  // result slot free or being drained this cycle
  assign commit     = (state_q == S_UPD) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE) || commit;
  assign load       = in_valid_i && in_ready_o;

  assign cmd_o.load_op = load;
  assign cmd_o.cmp_en  = (state_q == S_CMP);
  assign cmd_o.commit  = commit;
  assign out_valid_o   = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (load) state_d = S_CMP;
      S_CMP:  state_d = S_UPD;
      S_UPD: begin
        if (commit) state_d = load ? S_CMP : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/svt_dp.sv =====
module svt_dp
  import svt_pkg::*;
#(
  parameter int unsigned CAPACITY = SvtCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  svt_cmd_t           cmd_i,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  output logic [1:0]         status_o,
  output logic               present_o,
  output logic [6:0]         entry_count_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic signed [31:0] entry_q [CAPACITY];
  logic [CW-1:0]      count_q, count_d;
  logic [1:0]         op_mode_q;
  logic signed [31:0] op_value_q;

  logic [CAPACITY-1:0] gt_q;   // held entry greater than operand
  logic [CAPACITY-1:0] ge_q;   // held entry greater or equal
  logic                any_eq_q;
  logic [CAPACITY-1:0] gt_c, ge_c, eq_c;

  logic do_ins, do_rem, full;
  logic [1:0] status_d;
  logic [CW+6:0] count_ext;

  logic [1:0] status_q;
  logic       present_q;
  logic [6:0] entry_count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      op_mode_q  <= mode_i;
      op_value_q <= value_i;
    end
  end

  // compare all held entries against the operand
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
    logic vld;
    assign vld     = CW'(i) < count_q;
    assign gt_c[i] = vld && (entry_q[i] > op_value_q);
    assign ge_c[i] = vld && (entry_q[i] >= op_value_q);
    assign eq_c[i] = vld && (entry_q[i] == op_value_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      gt_q     <= gt_c;
      ge_q     <= ge_c;
      any_eq_q <= |eq_c;
    end
  end

  assign full   = (count_q == CW'(CAPACITY));
  assign do_ins = cmd_i.commit && (op_mode_q == MODE_INSERT) && !full;
  assign do_rem = cmd_i.commit && (op_mode_q == MODE_REMOVE) && any_eq_q;

  // shift network: insert opens a slot, remove closes the first match
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic ins_mv, ins_prev;
    assign ins_mv = gt_q[i] || (CW'(i) == count_q);
    if (i > 0) begin : g_prev
      assign ins_prev = gt_q[i-1];
    end else begin : g_first
      assign ins_prev = 1'b0;
    end
    always_ff @(posedge clk_i) begin
      if (do_ins && ins_mv) begin
        if (ins_prev) begin
          if (i > 0) entry_q[i] <= entry_q[(i > 0) ? i - 1 : 0];
        end else begin
          entry_q[i] <= op_value_q;
        end
      end else if (do_rem && ge_q[i]) begin
        if (i < CAPACITY - 1) entry_q[i] <= entry_q[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CW'(1);
    end else if (do_rem) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_comb begin
    status_d = ST_DONE;
    if ((op_mode_q == MODE_INSERT) && full) begin
      status_d = ST_FULL;
    end else if ((op_mode_q == MODE_REMOVE) && !any_eq_q) begin
      status_d = ST_ABSENT;
    end
  end

  assign count_ext = {7'b0, count_d};

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q      <= status_d;
      present_q     <= (op_mode_q == MODE_LOOKUP) && any_eq_q;
      entry_count_q <= count_ext[6:0];
    end
  end

  assign status_o      = status_q;
  assign present_o     = present_q;
  assign entry_count_o = entry_count_q;

endmodule

// ===== src/sorted_value_table.sv =====
// sorted_value_table: ascending table of signed 32-bit values.
// Each transaction is compared, then updated; the result register loads when the update
// commits, which waits while an unread result is held. The compare-then-shift of the
// register array takes one transaction at a time: next operand enters as the previous commits.
// Reset: asynchronous, active low; clears count and control, table contents
// stay undefined and are never read before written.
module sorted_value_table
  import svt_pkg::*;
#(
  parameter int unsigned CAPACITY = SvtCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               present_o,
  output logic [6:0]         entry_count_o
);

  // Controller sequences each transaction: IDLE -> CMP -> UPD.
  // UPD commits only when the result register is free or draining,
  // so a finished result can wait while the next operand is taken.
  svt_cmd_t cmd;

  svt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath: register array with per-entry comparators and a
  // neighbor shift network; insert shifts up past the first greater
  // entry, remove shifts down from the first equal one.
  svt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .status_o      (status_o),
    .present_o     (present_o),
    .entry_count_o (entry_count_o)
  );

  localparam int unsigned CapExtW = 32;
  localparam logic [CapExtW-1:0] CapExt = CapExtW'(CAPACITY);

`ifndef NO_ASSERTIONS
  // A refused insert always reports a full table.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |-> (entry_count_o == CapExt[6:0]))
    else $error("full status without full count");

  // Present only comes with a successful lookup.
  a_present_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && present_o) |-> (status_o == ST_DONE))
    else $error("present flagged on failed operation");

  // Result drains unless a new one commits in the same cycle.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !cmd.commit) |=> !out_valid_o)
    else $error("result repeated after transaction");

  // Commit never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.commit && out_valid_o) |-> out_ready_i)
    else $error("result overwritten");
`endif

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import svt_pkg::*;

  // Table depth of the instance below (default parameter)
  localparam int unsigned TableDepth = SvtCapacity;
  // The fourth mode encoding is a no-op on the block
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int RandomOps     = 1600;
  localparam int CycleLimit    = 300000;
  localparam int DrainCycles   = 20;
  localparam int HoldOffCycles = 400;
  localparam int HoldOffAfter  = 300;

  localparam logic signed [31:0] MinValue = 32'sh8000_0000;
  localparam logic signed [31:0] MaxValue = 32'sh7fff_ffff;

  // One result transaction, field by field
  typedef struct packed {
    logic [1:0] status;
    logic       present;
    logic [6:0] entry_count;
  } table_result_t;

  // Directed row: operation, operand and, where obvious, the result to expect
  typedef struct {
    logic [1:0]         mode;
    logic signed [31:0] value;
    bit                 typed;
    table_result_t      want;
  } table_row_t;

  // Receiver stall patterns
  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_EVERY_THIRD
  } ready_style_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         mode_i;
  logic signed [31:0] value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic               present_o;
  logic [6:0]         entry_count_o;

  // Shadow of the table contents, kept in ascending order
  logic signed [31:0] held_values [$];
  // Results still owed by the block, oldest first
  table_result_t      owed_results [$];

  int  burst_left    = 0;
  int  ops_issued    = 0;
  int  results_seen  = 0;
  int  mismatches    = 0;
  int  full_refusals = 0;
  int  absent_misses = 0;
  int  lookup_hits   = 0;
  int  cycle_count   = 0;
  bit  held_off      = 1'b0;

  sorted_value_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .present_o     (present_o),
    .entry_count_o (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Applies one operation to the shadow table and returns its result.
  // Insert goes after every held value <= operand; remove takes the first match.
  function automatic table_result_t apply_table_op(input logic [1:0] mode,
                                                    input logic signed [31:0] value);
    table_result_t res;
    int            pos;
    res.status  = ST_DONE;
    res.present = 1'b0;
    pos = 0;
    case (mode)
      MODE_INSERT: begin
        if (held_values.size() >= TableDepth) begin
          res.status = ST_FULL;
        end else begin
          while (pos < held_values.size() && held_values[pos] <= value) pos++;
          held_values.insert(pos, value);
        end
      end
      MODE_REMOVE: begin
        while (pos < held_values.size() && held_values[pos] != value) pos++;
        if (pos == held_values.size()) res.status = ST_ABSENT;
        else held_values.delete(pos);
      end
      MODE_LOOKUP: begin
        while (pos < held_values.size() && held_values[pos] != value) pos++;
        res.present = (pos < held_values.size());
      end
      default: ;
    endcase
    res.entry_count = 7'(held_values.size());
    return res;
  endfunction

  // Operand mix: corners, a narrow band around zero (for duplicates),
  // values already held (for hits), and full-range noise.
  function automatic logic signed [31:0] pick_operand();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      case ($urandom_range(0, 5))
        0:       return MinValue;
        1:       return MinValue + 1;
        2:       return MaxValue;
        3:       return MaxValue - 1;
        4:       return -32'sd1;
        default: return 32'sd0;
      endcase
    end else if (sel < 5) begin
      return $signed(32'($urandom_range(0, 40))) - 32'sd20;
    end else if (sel < 7 && held_values.size() > 0) begin
      return held_values[$urandom_range(0, held_values.size() - 1)];
    end
    return $urandom;
  endfunction

  // Offers one input transaction, holding it until accepted. The sender runs in
  // bursts; when a burst is used up, valid drops for a random gap first.
  task automatic issue_op(input logic [1:0] mode, input logic signed [31:0] value,
                          input bit typed, input table_result_t want);
    table_result_t res;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    // accepted at this edge: update the shadow table in acceptance order
    res = apply_table_op(mode, value);
    owed_results.push_back(typed ? want : res);
    ops_issued++;
    if (res.status == ST_FULL) full_refusals++;
    if (res.status == ST_ABSENT) absent_misses++;
    if (res.present) lookup_hits++;
  endtask

  // Stimulus
  initial begin
    table_row_t dir_rows [24];
    int         rand_ops;
    int         episode;
    int         kind;
    int         span;
    int         sel;

    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    mode_i     <= MODE_INSERT;
    value_i    <= '0;

    dir_rows = '{
      // empty table: lookup miss, remove miss, no-op
      '{MODE_LOOKUP, 32'sd0,       1'b1, '{ST_DONE,   1'b0, 7'd0}},
      '{MODE_REMOVE, 32'sd5,       1'b1, '{ST_ABSENT, 1'b0, 7'd0}},
      '{MODE_UNUSED, 32'sd7,       1'b1, '{ST_DONE,   1'b0, 7'd0}},
      // insert into empty, then extremes and a duplicate
      '{MODE_INSERT, 32'sd0,       1'b1, '{ST_DONE,   1'b0, 7'd1}},
      '{MODE_INSERT, MinValue,     1'b1, '{ST_DONE,   1'b0, 7'd2}},
      '{MODE_INSERT, MaxValue,     1'b1, '{ST_DONE,   1'b0, 7'd3}},
      '{MODE_INSERT, -32'sd1,      1'b1, '{ST_DONE,   1'b0, 7'd4}},
      '{MODE_INSERT, 32'sd0,       1'b1, '{ST_DONE,   1'b0, 7'd5}},
      '{MODE_LOOKUP, MinValue,     1'b1, '{ST_DONE,   1'b1, 7'd5}},
      '{MODE_LOOKUP, MaxValue,     1'b1, '{ST_DONE,   1'b1, 7'd5}},
      '{MODE_LOOKUP, 32'sd1,       1'b1, '{ST_DONE,   1'b0, 7'd5}},
      '{MODE_LOOKUP, -32'sd2,      1'b0, '0},
      // removing one copy of a duplicate leaves the other
      '{MODE_REMOVE, 32'sd0,       1'b1, '{ST_DONE,   1'b0, 7'd4}},
      '{MODE_LOOKUP, 32'sd0,       1'b1, '{ST_DONE,   1'b1, 7'd4}},
      '{MODE_UNUSED, MinValue,     1'b1, '{ST_DONE,   1'b0, 7'd4}},
      '{MODE_REMOVE, MaxValue,     1'b1, '{ST_DONE,   1'b0, 7'd3}},
      '{MODE_REMOVE, MaxValue,     1'b1, '{ST_ABSENT, 1'b0, 7'd3}},
      // alternating bit patterns on the operand
      '{MODE_INSERT, 32'sh5555_5555, 1'b0, '0},
      '{MODE_INSERT, 32'shAAAA_AAAA, 1'b0, '0},
      '{MODE_REMOVE, MinValue,     1'b1, '{ST_DONE,   1'b0, 7'd4}},
      '{MODE_REMOVE, -32'sd1,      1'b0, '0},
      '{MODE_REMOVE, 32'sd0,       1'b0, '0},
      '{MODE_REMOVE, 32'sh5555_5555, 1'b0, '0},
      // last removal empties the table again
      '{MODE_REMOVE, 32'shAAAA_AAAA, 1'b1, '{ST_DONE,   1'b0, 7'd0}}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      issue_op(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part in episodes; the first one always fills the table
    rand_ops = 0;
    episode  = 0;
    while (rand_ops < RandomOps) begin
      kind = (episode == 0) ? 0 : $urandom_range(0, 9);
      if (kind < 2) begin
        // fill to capacity, then hit the full table a few times
        while (held_values.size() < TableDepth) begin
          issue_op(MODE_INSERT, pick_operand(), 1'b0, '0);
          rand_ops++;
        end
        repeat ($urandom_range(1, 3)) begin
          issue_op(MODE_INSERT, pick_operand(), 1'b0, '0);
          rand_ops++;
        end
      end else if (kind < 4) begin
        // drain: mostly removes of held values, some misses and lookups
        span = $urandom_range(5, 80);
        while (span > 0 && held_values.size() > 0) begin
          sel = $urandom_range(0, 9);
          if (sel == 0) begin
            issue_op(MODE_REMOVE, $urandom, 1'b0, '0);
          end else if (sel == 1) begin
            issue_op(MODE_LOOKUP, pick_operand(), 1'b0, '0);
          end else begin
            issue_op(MODE_REMOVE, held_values[$urandom_range(0, held_values.size() - 1)],
                     1'b0, '0);
          end
          span--;
          rand_ops++;
        end
      end else begin
        // mixed traffic
        repeat ($urandom_range(10, 60)) begin
          sel = $urandom_range(0, 19);
          if (sel < 8) issue_op(MODE_INSERT, pick_operand(), 1'b0, '0);
          else if (sel < 14) issue_op(MODE_REMOVE, pick_operand(), 1'b0, '0);
          else if (sel < 19) issue_op(MODE_LOOKUP, pick_operand(), 1'b0, '0);
          else issue_op(MODE_UNUSED, pick_operand(), 1'b0, '0);
          rand_ops++;
        end
      end
      episode++;
    end
    in_valid_i <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d operations: %0d inserts refused on a full table, %0d removes missed,",
             ops_issued, full_refusals, absent_misses);
    $display("%0d lookup hits; %0d results checked, %0d mismatches.",
             lookup_hits, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: random stall patterns, plus one long hold-off so the block
  // backs up and has to stall its input side.
  initial begin
    ready_style_e style;
    int           span;
    int           k;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && results_seen >= HoldOffAfter) begin
        held_off = 1'b1;
        @(posedge clk_i);
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles - 1) @(posedge clk_i);
      end
      style = ready_style_e'($urandom_range(0, 3));
      span  = $urandom_range(10, 150);
      for (k = 0; k < span; k++) begin
        @(posedge clk_i);
        case (style)
          READY_ALWAYS: out_ready_i <= 1'b1;
          READY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          READY_SPARSE: out_ready_i <= ($urandom_range(0, 4) == 0);
          default:      out_ready_i <= (k % 3 == 0);
        endcase
      end
    end
  end

  // Result checker: every output transaction against the oldest expectation
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d present %0d count %0d",
                 $time, status_o, present_o, entry_count_o);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, status_o);
          mismatches++;
        end
        if (present_o !== want.present) begin
          $display("%0t: present mismatch: expected %0d actual %0d",
                   $time, want.present, present_o);
          mismatches++;
        end
        if (entry_count_o !== want.entry_count) begin
          $display("%0t: entry_count mismatch: expected %0d actual %0d",
                   $time, want.entry_count, entry_count_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results still owed",
               $time, cycle_count, owed_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
